[design/rgb_gamma_curve_approx_defines.svh]
// ============================================================================
// rgb_gamma_curve_approx_defines.svh
// Assertion macros shared by the gamma curve block.
// ============================================================================
`ifndef RGB_GAMMA_CURVE_APPROX_DEFINES_SVH
`define RGB_GAMMA_CURVE_APPROX_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RGC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_gamma_curve_approx: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_gamma_curve_approx: next-cycle check failed");

`endif

[design/rgc_pkg.sv]
// ============================================================================
// rgc_pkg
// Shared widths, register codes, curve tables and pipeline control types.
// ============================================================================
`default_nettype none

package rgc_pkg;

  localparam int PIX_W    = 8;
  localparam int GAMMA_W  = 10;
  localparam int WEIGHT_W = 9;
  localparam int DIFF_W   = 16;
  localparam int PROD_W   = DIFF_W + WEIGHT_W;
  localparam int Y_W      = DIFF_W + 1;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [GAMMA_W-1:0]  GAMMA_ONE    = GAMMA_W'(256);
  localparam logic [GAMMA_W-1:0]  GAMMA_CLIP   = GAMMA_W'(512);
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = WEIGHT_W'(256);

  // Register index of the only configuration register.
  localparam logic REG_GAMMA = 1'b0;

  typedef logic [DIFF_W-1:0] curve_tab_t [256];

  // Per-stage load enables handed from the control unit to the datapaths.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_ctrl_t;

  // Lift target: floor(sqrt(255 * v * 65536)), evaluated at elaboration.
  function automatic curve_tab_t build_sqrt_tab();
    curve_tab_t  tab;
    logic [33:0] n;
    logic [33:0] root;
    logic [33:0] bitv;
    for (int v = 0; v < 256; v++) begin
      n    = 34'(255 * v) << 16;
      root = '0;
      bitv = 34'd1 << 30;
      for (int i = 0; i < 16; i++) begin
        if (n >= root + bitv) begin
          n    = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      tab[v] = root[DIFF_W-1:0];
    end
    return tab;
  endfunction

  // Crush target: floor(v * v * 256 / 255), evaluated at elaboration.
  function automatic curve_tab_t build_crush_tab();
    curve_tab_t tab;
    for (int v = 0; v < 256; v++) begin
      tab[v] = DIFF_W'((v * v * 256) / 255);
    end
    return tab;
  endfunction

  localparam curve_tab_t SQRT_TAB  = build_sqrt_tab();
  localparam curve_tab_t CRUSH_TAB = build_crush_tab();

endpackage

`default_nettype wire

[design/rgc_pipe_ctrl.sv]
// ============================================================================
// rgc_pipe_ctrl
// Valid bits and stall propagation for the three-stage pixel pipeline.
// ============================================================================
`default_nettype none

module rgc_pipe_ctrl
  import rgc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  output stage_ctrl_t      ctrl,
  output logic [2:0]       stage_vld
);

  logic vld1_r, vld2_r, vld3_r;
  logic rdy1, rdy2, rdy3;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    rdy3     = !vld3_r || !out_stall;
    rdy2     = !vld2_r || rdy3;
    rdy1     = !vld1_r || rdy2;
    ctrl.ld1 = rdy1 && in_valid;
    ctrl.ld2 = rdy2 && vld1_r;
    ctrl.ld3 = rdy3 && vld2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        vld1_r <= in_valid;
      end
      if (rdy2) begin
        vld2_r <= vld1_r;
      end
      if (rdy3) begin
        vld3_r <= vld2_r;
      end
    end
  end

  assign in_stall  = !rdy1;
  assign out_valid = vld3_r;
  assign stage_vld = {vld3_r, vld2_r, vld1_r};

endmodule

`default_nettype wire

[design/rgc_channel.sv]
// ============================================================================
// rgc_channel
// Three-stage gamma curve datapath for one 8-bit color channel.
// ============================================================================
`default_nettype none

module rgc_channel
  import rgc_pkg::*;
(
  input  wire logic                clk,
  input  wire stage_ctrl_t         ctrl,
  input  wire logic                lift,
  input  wire logic [WEIGHT_W-1:0] weight,
  input  wire logic [PIX_W-1:0]    pix_in,
  output logic [PIX_W-1:0]         pix_out
);

  logic [PIX_W-1:0]  base1_r, base2_r;
  logic [DIFF_W-1:0] diff1_r;
  logic [DIFF_W-1:0] diff1_nxt;
  logic [PROD_W-1:0] prod2_r;
  logic [PROD_W-1:0] prod2_nxt;
  logic [Y_W-1:0]    base_fx;
  logic [Y_W-1:0]    y_fx;
  logic [Y_W-1:0]    y_rnd;
  logic [PIX_W:0]    out_wide;
  logic [PIX_W-1:0]  out_r;
  logic [PIX_W-1:0]  out_nxt;

  // Stage 1: distance from the input level to the target curve.
  always_comb begin
    if (lift) begin
      diff1_nxt = SQRT_TAB[pix_in] - {pix_in, 8'h00};
    end else begin
      diff1_nxt = {pix_in, 8'h00} - CRUSH_TAB[pix_in];
    end
  end

  // Stage 2: scale the distance by the blend weight.
  assign prod2_nxt = PROD_W'(diff1_r) * PROD_W'(weight);

  // Stage 3: apply the scaled step, round half up and clamp.
  always_comb begin
    base_fx  = {1'b0, base2_r, 8'h00};
    if (lift) begin
      y_fx = base_fx + prod2_r[PROD_W-1:8];
    end else begin
      y_fx = base_fx - prod2_r[PROD_W-1:8];
    end
    y_rnd    = y_fx + Y_W'(128);
    out_wide = y_rnd[Y_W-1:8];
    out_nxt  = out_wide[PIX_W] ? {PIX_W{1'b1}} : out_wide[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      base1_r <= pix_in;
      diff1_r <= diff1_nxt;
    end
    if (ctrl.ld2) begin
      base2_r <= base1_r;
      prod2_r <= prod2_nxt;
    end
    if (ctrl.ld3) begin
      out_r <= out_nxt;
    end
  end

  assign pix_out = out_r;

endmodule

`default_nettype wire

[design/rgb_gamma_curve_approx.sv]
// ============================================================================
// rgb_gamma_curve_approx
// Approximate gamma curve on 8-bit RGB pixels, one pixel per clock while the output is not stalled.
// ============================================================================
`default_nettype none

`include "rgb_gamma_curve_approx_defines.svh"

// This block applies a cheap gamma curve to each channel of an 8-bit RGB
// pixel. The gamma register holds g times 256. Below identity each channel is
// blended toward sqrt(255*v) with weight 1-g; above identity it is blended
// toward v*v/255 with weight min(g-1,1); at identity (256) the pixel passes
// through unchanged. Blending is done with 8 fractional bits and the result is
// rounded half up and clamped to 0..255. The datapath is a three-stage
// pipeline (curve table lookup, weight multiply, round and clamp). A
// transaction accepted at the input passes through the stage 1, stage 2 and
// output registers in turn before it is presented on the output. While
// nothing stalls, a new transaction can be taken every cycle. A stall at the
// output holds the pipeline; in_stall only rises once all three stages are
// full and the output is stalled. The gamma register sits on an APB-style
// port at byte address 0 and should only be written while the pipeline is
// empty.
module rgb_gamma_curve_approx
  import rgc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0]      cfg_prdata,
  output logic                   cfg_pready,
  // Input pixel channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [PIX_W-1:0]  in_red_in,
  input  wire logic [PIX_W-1:0]  in_green_in,
  input  wire logic [PIX_W-1:0]  in_blue_in,
  // Result pixel channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [PIX_W-1:0]       out_red_out,
  output logic [PIX_W-1:0]       out_green_out,
  output logic [PIX_W-1:0]       out_blue_out
);

  logic [GAMMA_W-1:0]  gamma_r;
  logic                cfg_wr;
  logic                lift;
  logic [WEIGHT_W-1:0] weight;
  stage_ctrl_t         ctrl;
  logic [2:0]          stage_vld;

  // The register index is the word address; only word 0 exists.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_GAMMA);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_ONE;
    end else if (cfg_wr) begin
      gamma_r <= cfg_pwdata[GAMMA_W-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_GAMMA) begin
      cfg_prdata = DATA_W'(gamma_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  // Blend direction and weight. Identity gamma gives a zero weight, so the
  // crush path then reproduces the input exactly.
  always_comb begin
    lift = gamma_r < GAMMA_ONE;
    if (lift) begin
      weight = WEIGHT_W'(GAMMA_ONE - gamma_r);
    end else if (gamma_r > GAMMA_CLIP) begin
      weight = WEIGHT_FULL;
    end else begin
      weight = WEIGHT_W'(gamma_r - GAMMA_ONE);
    end
  end

  rgc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .stage_vld (stage_vld)
  );

  rgc_channel u_red (
    .clk     (clk),
    .ctrl    (ctrl),
    .lift    (lift),
    .weight  (weight),
    .pix_in  (in_red_in),
    .pix_out (out_red_out)
  );

  rgc_channel u_green (
    .clk     (clk),
    .ctrl    (ctrl),
    .lift    (lift),
    .weight  (weight),
    .pix_in  (in_green_in),
    .pix_out (out_green_out)
  );

  rgc_channel u_blue (
    .clk     (clk),
    .ctrl    (ctrl),
    .lift    (lift),
    .weight  (weight),
    .pix_in  (in_blue_in),
    .pix_out (out_blue_out)
  );

  // Back-pressure reaches the input only when every stage holds a pixel.
  `RGC_ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, in_stall, (stage_vld == 3'b111) && out_stall)
  // A middle-stage pixel that cannot move on is still there next cycle.
  `RGC_ASSERT_NEXT(a_mid_stage_held, clk, rst_n, stage_vld[1] && stage_vld[2] && out_stall, stage_vld[1])
  // The blend weight never exceeds one.
  `RGC_ASSERT_IMPLY(a_weight_range, clk, rst_n, 1'b1, weight <= WEIGHT_FULL)
  // Identity gamma never blends.
  `RGC_ASSERT_IMPLY(a_identity_no_blend, clk, rst_n, gamma_r == GAMMA_ONE, weight == '0)

endmodule

`default_nettype wire
